/* rtl/rx256_pkg.sv */
// Shared types, constants and palette helper functions for the xterm-256 nearest-color block.
package rx256_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned SqW       = 16;
  localparam int unsigned DistW     = 18;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned NumSys    = 16;
  localparam int unsigned NumGroups = 4;
  localparam int unsigned GroupSize = NumSys / NumGroups;
  localparam int unsigned NumLevels = 4;
  localparam int unsigned NumGray   = 24;
  localparam int unsigned GrayBase  = 8;
  localparam int unsigned GrayStep  = 10;
  localparam int unsigned CubeFirst = 16;
  localparam int unsigned GrayFirst = 232;
  localparam int unsigned NumStages = 7;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [SqW-1:0]   sq_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [2:0]       digit_t;
  typedef logic [4:0]       gray_idx_t;
  typedef logic [3:0]       sys_idx_t;
  typedef logic [1:0]       sys_code_t;
  typedef logic [9:0]       sum_t;

  localparam sys_code_t SysZero = 2'd0;
  localparam sys_code_t Sys128  = 2'd1;
  localparam sys_code_t Sys192  = 2'd2;
  localparam sys_code_t Sys255  = 2'd3;

  function automatic chan_t sys_level(input sys_code_t code);
    chan_t lvl;
    unique case (code)
      SysZero: lvl = 8'd0;
      Sys128:  lvl = 8'd128;
      Sys192:  lvl = 8'd192;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // Level code of one channel of a system color.
  function automatic sys_code_t sys_code(input int unsigned idx, input int unsigned chan);
    sys_code_t   lvl;
    logic [2:0]  mask;
    case (idx)
      0:                  lvl = SysZero;
      1, 2, 3, 4, 5, 6, 8: lvl = Sys128;
      7:                  lvl = Sys192;
      default:            lvl = Sys255;
    endcase
    case (idx % 8)
      0:       mask = 3'd7;
      1:       mask = 3'd1;
      2:       mask = 3'd2;
      3:       mask = 3'd3;
      4:       mask = 3'd4;
      5:       mask = 3'd5;
      6:       mask = 3'd6;
      default: mask = 3'd7;
    endcase
    return mask[chan[1:0]] ? lvl : SysZero;
  endfunction

  function automatic chan_t cube_level(input digit_t d);
    chan_t lvl;
    unique case (d)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // Nearest cube level per channel, lower level on ties.
  function automatic digit_t cube_digit(input chan_t x);
    digit_t d;
    if (x <= 8'd47) begin
      d = 3'd0;
    end else if (x <= 8'd115) begin
      d = 3'd1;
    end else if (x <= 8'd155) begin
      d = 3'd2;
    end else if (x <= 8'd195) begin
      d = 3'd3;
    end else if (x <= 8'd235) begin
      d = 3'd4;
    end else begin
      d = 3'd5;
    end
    return d;
  endfunction

  // Nearest gray step: the first k whose successor is not closer,
  // i.e. 2*sum <= 3*(g_k + g_k+1).
  function automatic gray_idx_t gray_idx(input sum_t sum);
    gray_idx_t  k;
    logic [10:0] twice;
    twice = {sum, 1'b0};
    k = gray_idx_t'(NumGray - 1);
    for (int j = NumGray - 2; j >= 0; j--) begin
      if (twice <= 11'(3 * (2 * GrayBase + GrayStep + 2 * GrayStep * j))) begin
        k = gray_idx_t'(j);
      end
    end
    return k;
  endfunction

  function automatic chan_t gray_level(input gray_idx_t k);
    return chan_t'(GrayBase + GrayStep * int'(k));
  endfunction

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic sq_t square(input chan_t x);
    return sq_t'({8'd0, x} * {8'd0, x});
  endfunction

endpackage

/* rtl/rx256_sys_min.sv */
// Two-stage minimum search over the sixteen system-color distances.
module rx256_sys_min (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  rx256_pkg::dist_t    dist_i [rx256_pkg::NumSys],
  output rx256_pkg::dist_t    best_dist_o,
  output rx256_pkg::sys_idx_t best_idx_o
);
  import rx256_pkg::*;

  dist_t    grp_dist_d [NumGroups];
  sys_idx_t grp_idx_d  [NumGroups];
  dist_t    grp_dist_q [NumGroups];
  sys_idx_t grp_idx_q  [NumGroups];
  dist_t    best_dist_d, best_dist_q;
  sys_idx_t best_idx_d, best_idx_q;

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_dist_d[g] = dist_i[g * GroupSize];
      grp_idx_d[g]  = sys_idx_t'(g * GroupSize);
      for (int m = 1; m < GroupSize; m++) begin
        if (dist_i[g * GroupSize + m] < grp_dist_d[g]) begin
          grp_dist_d[g] = dist_i[g * GroupSize + m];
          grp_idx_d[g]  = sys_idx_t'(g * GroupSize + m);
        end
      end
    end
  end

  always_comb begin
    best_dist_d = grp_dist_q[0];
    best_idx_d  = grp_idx_q[0];
    for (int g = 1; g < NumGroups; g++) begin
      if (grp_dist_q[g] < best_dist_d) begin
        best_dist_d = grp_dist_q[g];
        best_idx_d  = grp_idx_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      grp_dist_q <= grp_dist_d;
      grp_idx_q  <= grp_idx_d;
    end
    if (en_i[1]) begin
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
    end
  end

  assign best_dist_o = best_dist_q;
  assign best_idx_o  = best_idx_q;

endmodule

/* rtl/rgb_to_xterm256_nearest.sv */
// Seven register stages: per-channel cube/gray pick, differences, squares,
// distance sums, two system-color minimum stages, final three-way select.
// Throughput: one pixel per cycle while the output is not stalled.
// Stages advance independently, so bubbles close up and a stalled output holds all data.
// Reset (rst_ni, asynchronous, active low) clears the stage valid bits only.
// Top level: nearest xterm 256-color index for an 8-bit RGB pixel.
module rgb_to_xterm256_nearest (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] color_index_o
);
  import rx256_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  chan_t     pix_d [NumChan];
  chan_t     pix_q [NumChan];
  digit_t    digit_q [NumChan];
  gray_idx_t gray_k_q;
  sum_t      sum_d;

  chan_t     sys_diff_q  [NumChan][NumLevels];
  chan_t     cube_diff_q [NumChan];
  chan_t     gray_diff_q [NumChan];
  logic [7:0] cube_idx_q [4];
  gray_idx_t gray_k_p_q  [4];

  sq_t       sys_sq_q  [NumChan][NumLevels];
  sq_t       cube_sq_q [NumChan];
  sq_t       gray_sq_q [NumChan];

  dist_t     sys_dist_q [NumSys];
  dist_t     cube_dist_q [3];
  dist_t     gray_dist_q [3];

  dist_t     sys_best_dist;
  sys_idx_t  sys_best_idx;
  logic [7:0] color_index_d, color_index_q;
  dist_t     final_dist;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign pix_d[0] = red_i;
  assign pix_d[1] = green_i;
  assign pix_d[2] = blue_i;
  assign sum_d = sum_t'(red_i) + sum_t'(green_i) + sum_t'(blue_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int c = 0; c < NumChan; c++) begin
        pix_q[c]   <= pix_d[c];
        digit_q[c] <= cube_digit(pix_d[c]);
      end
      gray_k_q <= gray_idx(sum_d);
    end
    if (en[1]) begin
      for (int c = 0; c < NumChan; c++) begin
        for (int l = 0; l < NumLevels; l++) begin
          sys_diff_q[c][l] <= abs_diff(pix_q[c], sys_level(sys_code_t'(l)));
        end
        cube_diff_q[c] <= abs_diff(pix_q[c], cube_level(digit_q[c]));
        gray_diff_q[c] <= abs_diff(pix_q[c], gray_level(gray_k_q));
      end
      cube_idx_q[0] <= 8'(CubeFirst + 36 * int'(digit_q[0]) + 6 * int'(digit_q[1])
                          + int'(digit_q[2]));
      gray_k_p_q[0] <= gray_k_q;
    end
    if (en[2]) begin
      for (int c = 0; c < NumChan; c++) begin
        for (int l = 0; l < NumLevels; l++) begin
          sys_sq_q[c][l] <= square(sys_diff_q[c][l]);
        end
        cube_sq_q[c] <= square(cube_diff_q[c]);
        gray_sq_q[c] <= square(gray_diff_q[c]);
      end
      cube_idx_q[1] <= cube_idx_q[0];
      gray_k_p_q[1] <= gray_k_p_q[0];
    end
    if (en[3]) begin
      for (int i = 0; i < NumSys; i++) begin
        sys_dist_q[i] <= dist_t'(sys_sq_q[0][sys_code(i, 0)])
                       + dist_t'(sys_sq_q[1][sys_code(i, 1)])
                       + dist_t'(sys_sq_q[2][sys_code(i, 2)]);
      end
      cube_dist_q[0] <= dist_t'(cube_sq_q[0]) + dist_t'(cube_sq_q[1])
                      + dist_t'(cube_sq_q[2]);
      gray_dist_q[0] <= dist_t'(gray_sq_q[0]) + dist_t'(gray_sq_q[1])
                      + dist_t'(gray_sq_q[2]);
      cube_idx_q[2] <= cube_idx_q[1];
      gray_k_p_q[2] <= gray_k_p_q[1];
    end
    if (en[4]) begin
      cube_dist_q[1] <= cube_dist_q[0];
      gray_dist_q[1] <= gray_dist_q[0];
      cube_idx_q[3]  <= cube_idx_q[2];
      gray_k_p_q[3]  <= gray_k_p_q[2];
    end
    if (en[5]) begin
      cube_dist_q[2] <= cube_dist_q[1];
      gray_dist_q[2] <= gray_dist_q[1];
    end
    if (en[6]) begin
      color_index_q <= color_index_d;
    end
  end

  rx256_sys_min u_sys_min (
    .clk_i      (clk_i),
    .en_i       (en[5:4]),
    .dist_i     (sys_dist_q),
    .best_dist_o(sys_best_dist),
    .best_idx_o (sys_best_idx)
  );

  // Carry the cube index and gray step alongside their distances through the second system-color minimum stage.
  logic [7:0] cube_idx_s6_q;
  gray_idx_t  gray_k_s6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      cube_idx_s6_q <= cube_idx_q[3];
      gray_k_s6_q   <= gray_k_p_q[3];
    end
  end

  always_comb begin
    final_dist    = sys_best_dist;
    color_index_d = {4'd0, sys_best_idx};
    if (cube_dist_q[2] < final_dist) begin
      final_dist    = cube_dist_q[2];
      color_index_d = cube_idx_s6_q;
    end
    if (gray_dist_q[2] < final_dist) begin
      color_index_d = 8'(GrayFirst) + 8'(gray_k_s6_q);
    end
  end

  assign out_valid_o   = valid_q[NumStages-1];
  assign color_index_o = color_index_q;

endmodule

/* tb/rgb_to_xterm256_nearest_tb.sv */
// Self-checking testbench for rgb_to_xterm256_nearest: pixel transfers scored by a palette search.
`timescale 1ns / 100ps

class nearest_color_scoreboard;
  logic [7:0]  expected_q[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  function void palette_rgb(input int unsigned idx, output int unsigned pr, pg, pb);
    int unsigned lvl;
    int unsigned mask;
    int unsigned t;
    if (idx < rx256_pkg::CubeFirst) begin
      case (idx)
        0:       lvl = 0;
        7:       lvl = 192;
        8:       lvl = 128;
        default: lvl = (idx < 8) ? 128 : 255;
      endcase
      mask = (idx % 8 == 0) ? 7 : idx % 8;
      pr = mask[0] ? lvl : 0;
      pg = mask[1] ? lvl : 0;
      pb = mask[2] ? lvl : 0;
    end else if (idx < rx256_pkg::GrayFirst) begin
      t  = idx - rx256_pkg::CubeFirst;
      pr = (t / 36 == 0) ? 0 : 55 + 40 * (t / 36);
      pg = ((t / 6) % 6 == 0) ? 0 : 55 + 40 * ((t / 6) % 6);
      pb = (t % 6 == 0) ? 0 : 55 + 40 * (t % 6);
    end else begin
      pr = rx256_pkg::GrayBase + rx256_pkg::GrayStep * (idx - rx256_pkg::GrayFirst);
      pg = pr;
      pb = pr;
    end
  endfunction

  function logic [7:0] nearest_index(input logic [7:0] r, g, b);
    int unsigned pr, pg, pb;
    int          dr, dg, db;
    int unsigned sq_dist;
    int unsigned best_dist;
    int unsigned best_idx;
    best_dist = 32'hFFFF_FFFF;
    best_idx  = 0;
    for (int unsigned i = 0; i < 256; i++) begin
      palette_rgb(i, pr, pg, pb);
      dr      = int'(r) - int'(pr);
      dg      = int'(g) - int'(pg);
      db      = int'(b) - int'(pb);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best_idx  = i;
      end
    end
    return best_idx[7:0];
  endfunction

  function void note_pixel(input logic [7:0] r, g, b);
    expected_q.insert(expected_q.size(), nearest_index(r, g, b));
  endfunction

  function void check_index(input logic [7:0] actual);
    logic [7:0] want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected color index: expected none, actual %0d", $time, actual);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (want !== actual) begin
        $display("%0t: color index mismatch: expected %0d, actual %0d", $time, want, actual);
        mismatches++;
      end
    end
  endfunction
endclass

module rgb_to_xterm256_nearest_tb;
  localparam int unsigned NumRandom     = 900;
  localparam int unsigned CalmItems     = 100;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned WatchdogLimit = 3000;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       pix_valid = 1'b0;
  logic       pix_ready;
  logic [7:0] pix_red   = 8'd0;
  logic [7:0] pix_green = 8'd0;
  logic [7:0] pix_blue  = 8'd0;
  logic       idx_valid;
  logic       idx_ready = 1'b0;
  logic [7:0] idx_value;

  bit          calm          = 1'b0;
  bit          no_gaps       = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned idle_cycles   = 0;

  nearest_color_scoreboard sb = new();

  rgb_to_xterm256_nearest i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pix_valid),
    .in_ready_o   (pix_ready),
    .red_i        (pix_red),
    .green_i      (pix_green),
    .blue_i       (pix_blue),
    .out_valid_o  (idx_valid),
    .out_ready_i  (idx_ready),
    .color_index_o(idx_value)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (pix_valid && pix_ready) begin
      sb.note_pixel(pix_red, pix_green, pix_blue);
    end
    if (idx_valid && idx_ready) begin
      sb.check_index(idx_value);
    end
    if ((pix_valid && pix_ready) || (idx_valid && idx_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : receiver
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        idx_ready      <= 1'b0;
        long_hold_done = 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        idx_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        idx_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, g, b);
    int unsigned gap;
    gap = 0;
    if (!calm && !no_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
    end
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_valid <= 1'b1;
    pix_red   <= r;
    pix_green <= g;
    pix_blue  <= b;
    @(posedge clk_i);
    while (!pix_ready) @(posedge clk_i);
  endtask

  function automatic logic [7:0] jitter(input int unsigned base, input int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_random_pixel();
    int unsigned pr, pg, pb;
    int unsigned pick;
    int unsigned gray;
    pick = $urandom_range(0, 3);
    case (pick)
      0, 1: begin
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
      2: begin
        sb.palette_rgb($urandom_range(0, 255), pr, pg, pb);
        send_pixel(jitter(pr, 6), jitter(pg, 6), jitter(pb, 6));
      end
      default: begin
        gray = $urandom_range(0, 255);
        send_pixel(jitter(gray, 2), jitter(gray, 2), jitter(gray, 2));
      end
    endcase
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd128, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd128, 8'd128);
    send_pixel(8'd192, 8'd192, 8'd192);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd4,   8'd4,   8'd4);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd48,  8'd48,  8'd48);
    send_pixel(8'd238, 8'd238, 8'd238);
    send_pixel(8'd95,  8'd95,  8'd95);
    send_pixel(8'd115, 8'd0,   8'd0);
    send_pixel(8'd47,  8'd155, 8'd235);
    send_pixel(8'd215, 8'd135, 8'd175);
    send_pixel(8'hAA,  8'h55,  8'hAA);
    send_pixel(8'h55,  8'hAA,  8'h55);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd3,   8'd8,   8'd13);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == 100) long_hold_req = 1'b1;
      if (n == NumRandom - CalmItems) calm = 1'b1;
      send_random_pixel();
    end
    pix_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
